[hw/rtl/fsh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsh_pkg: shared definitions for the error-diffusion halftone unit
// Field widths, register indexes and reset values, arithmetic constants and
// the position flags that travel with each pixel.
// ----------------------------------------------------------------------------
package fsh_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_WIDTH_DEF     = 1024;
	localparam int FRACTION_BITS_DEF = 8;

	// Interface field widths.
	localparam int CHAN_W     = 8;
	localparam int THR_W      = 9;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	// One lane per colour channel: red, green, blue.
	localparam int NUM_LANES = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

	// Register values after reset.
	localparam logic [THR_W-1:0]    THR_RESET    = 9'd128;
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 14'd1024;

	// Fixed-point arithmetic: stored values saturate at +-SAT_INT whole units,
	// which with the sign needs STORE_INT_W integer bits.
	localparam int SAT_INT     = 1023;
	localparam int STORE_INT_W = 11;
	localparam int FULL_LEVEL  = 255;

	// Diffusion weights, in sixteenths.
	localparam int WEIGHT_W     = 3;
	localparam int WEIGHT_SHIFT = 4;
	localparam logic [WEIGHT_W-1:0] W_RIGHT      = 3'd7;
	localparam logic [WEIGHT_W-1:0] W_DOWN_LEFT  = 3'd3;
	localparam logic [WEIGHT_W-1:0] W_DOWN       = 3'd5;
	localparam logic [WEIGHT_W-1:0] W_DOWN_RIGHT = 3'd1;

	// Where a pixel sits in the frame.
	typedef struct packed {
		logic first_col;
		logic first_row;
		logic last_col;
		logic last_row;
	} pos_t;

endpackage

[hw/rtl/fsh_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsh_lane: one colour channel of the error-diffusion core
// Thresholds the corrected channel value, forms the weighted errors and keeps
// the right-hand carry and the partial sums for the row below.
// ----------------------------------------------------------------------------
module fsh_lane #(
	parameter int FRACTION_BITS = fsh_pkg::FRACTION_BITS_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  fire,
	input  fsh_pkg::pos_t                                         pos,
	input  logic [fsh_pkg::THR_W-1:0]                             thr,
	input  logic [fsh_pkg::CHAN_W-1:0]                            pix,
	input  logic signed [FRACTION_BITS+fsh_pkg::STORE_INT_W-1:0]  row_err,
	output logic                                                  on,
	output logic signed [FRACTION_BITS+fsh_pkg::STORE_INT_W-1:0]  left_val,
	output logic signed [FRACTION_BITS+fsh_pkg::STORE_INT_W-1:0]  below_val
);

	localparam int SW = FRACTION_BITS + fsh_pkg::STORE_INT_W;
	localparam int VW = SW + 2;
	localparam int EW = SW + 1;
	localparam int PW = EW + 3;

	localparam logic signed [VW-1:0] LIM_V  = VW'(fsh_pkg::SAT_INT * (2 ** FRACTION_BITS));
	localparam logic signed [VW-1:0] NLIM_V = -LIM_V;
	localparam logic signed [EW-1:0] LIM_E  = EW'(fsh_pkg::SAT_INT * (2 ** FRACTION_BITS));
	localparam logic signed [EW-1:0] NLIM_E = -LIM_E;
	localparam logic signed [PW-1:0] LIM_P  = PW'(fsh_pkg::SAT_INT * (2 ** FRACTION_BITS));
	localparam logic signed [PW-1:0] NLIM_P = -LIM_P;
	localparam logic signed [EW-1:0] FULL_E = EW'(fsh_pkg::FULL_LEVEL * (2 ** FRACTION_BITS));
	localparam logic signed [EW-1:0] ZERO_E = '0;
	localparam logic signed [SW-1:0] ZERO_S = '0;

	function automatic logic signed [SW-1:0] sat_v(input logic signed [VW-1:0] a);
		logic signed [VW-1:0] r;
		begin
			if (a > LIM_V) r = LIM_V;
			else if (a < NLIM_V) r = NLIM_V;
			else r = a;
			return SW'(r);
		end
	endfunction

	function automatic logic signed [SW-1:0] sat_e(input logic signed [EW-1:0] a);
		logic signed [EW-1:0] r;
		begin
			if (a > LIM_E) r = LIM_E;
			else if (a < NLIM_E) r = NLIM_E;
			else r = a;
			return SW'(r);
		end
	endfunction

	// Error times k sixteenths, rounded towards minus infinity, saturated.
	function automatic logic signed [SW-1:0] weigh(
		input logic signed [EW-1:0]               e,
		input logic [fsh_pkg::WEIGHT_W-1:0]       k
	);
		logic signed [PW-1:0] ep;
		logic signed [PW-1:0] kp;
		logic signed [PW-1:0] q;
		logic signed [PW-1:0] r;
		begin
			ep = PW'(e);
			kp = PW'(k);
			q  = (ep * kp) >>> fsh_pkg::WEIGHT_SHIFT;
			if (q > LIM_P) r = LIM_P;
			else if (q < NLIM_P) r = NLIM_P;
			else r = q;
			return SW'(r);
		end
	endfunction

	logic signed [SW-1:0] right_q;
	logic signed [SW-1:0] pend_q;
	logic signed [SW-1:0] diag_q;

	logic signed [SW-1:0] right_eff;
	logic signed [SW-1:0] pend_eff;
	logic signed [SW-1:0] diag_eff;
	logic signed [SW-1:0] row_eff;
	logic signed [VW-1:0] pix_v;
	logic signed [VW-1:0] sum_v;
	logic signed [SW-1:0] val;
	logic signed [SW-1:0] thr_s;
	logic signed [EW-1:0] err;
	logic signed [SW-1:0] w_right;
	logic signed [SW-1:0] w_dleft;
	logic signed [SW-1:0] w_down;
	logic signed [SW-1:0] w_dright;

	always_comb begin
		right_eff = pos.first_col ? ZERO_S : right_q;
		pend_eff  = pos.first_col ? ZERO_S : pend_q;
		diag_eff  = pos.first_col ? ZERO_S : diag_q;
		row_eff   = pos.first_row ? ZERO_S : row_err;

		pix_v = VW'({pix, {FRACTION_BITS{1'b0}}});
		sum_v = pix_v + VW'(right_eff) + VW'(row_eff);
		val   = sat_v(sum_v);

		thr_s = SW'({thr, {FRACTION_BITS{1'b0}}});
		on    = (val >= thr_s);
		err   = EW'(val) - (on ? FULL_E : ZERO_E);

		w_right  = weigh(err, fsh_pkg::W_RIGHT);
		w_dleft  = weigh(err, fsh_pkg::W_DOWN_LEFT);
		w_down   = weigh(err, fsh_pkg::W_DOWN);
		w_dright = weigh(err, fsh_pkg::W_DOWN_RIGHT);

		left_val  = sat_e(EW'(pend_eff) + EW'(w_dleft));
		below_val = sat_e(EW'(diag_eff) + EW'(w_down));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q <= '0;
			pend_q  <= '0;
			diag_q  <= '0;
		end else if (fire) begin
			right_q <= pos.last_col ? ZERO_S : w_right;
			if (!pos.last_row) begin
				pend_q <= below_val;
				diag_q <= w_dright;
			end
		end
	end

endmodule

[hw/rtl/fsh_linebuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsh_linebuf: line buffer of error sums for the next row
// Single-port-write memory with a registered read, a one-entry store for the
// second write at the end of a row, and forwarding of a same-cycle write.
// ----------------------------------------------------------------------------
module fsh_linebuf #(
	parameter int DEPTH = fsh_pkg::MAX_WIDTH_DEF,
	parameter int DW    = fsh_pkg::NUM_LANES *
		(fsh_pkg::FRACTION_BITS_DEF + fsh_pkg::STORE_INT_W)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]            rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data,
	input  logic                     pend_set,
	input  logic [$clog2(DEPTH)-1:0] pend_addr,
	input  logic [DW-1:0]            pend_data
);

	localparam int AW = $clog2(DEPTH);

	logic [DW-1:0] mem [DEPTH];

	logic          pend_valid_q;
	logic [AW-1:0] pend_addr_q;
	logic [DW-1:0] pend_data_q;
	logic [DW-1:0] rd_q;
	logic          byp_q;
	logic [DW-1:0] byp_data_q;

	logic          drain;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [DW-1:0] mem_wd;

	// The held entry goes in on the first cycle with no other write.
	always_comb begin
		drain  = pend_valid_q && !wr_en;
		mem_we = wr_en || drain;
		mem_wa = wr_en ? wr_addr : pend_addr_q;
		mem_wd = wr_en ? wr_data : pend_data_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_q      <= mem_we && (mem_wa == rd_addr);
			byp_data_q <= mem_wd;
		end
		if (pend_set) begin
			pend_addr_q <= pend_addr;
			pend_data_q <= pend_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (pend_set) begin
			pend_valid_q <= 1'b1;
		end else if (drain) begin
			pend_valid_q <= 1'b0;
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

[hw/rtl/fsh_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsh_merge: joins the lane results
// Registers the output word and packs the lanes' row-below sums into line
// buffer writes.
// ----------------------------------------------------------------------------
module fsh_merge #(
	parameter int AW = $clog2(fsh_pkg::MAX_WIDTH_DEF),
	parameter int SW = fsh_pkg::FRACTION_BITS_DEF + fsh_pkg::STORE_INT_W
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     fire,
	input  logic                                     out_stall,
	input  fsh_pkg::pos_t                            pos,
	input  logic [AW-1:0]                            col,
	input  logic [fsh_pkg::NUM_LANES-1:0]            lane_on,
	input  logic [fsh_pkg::NUM_LANES-1:0][SW-1:0]    lane_left,
	input  logic [fsh_pkg::NUM_LANES-1:0][SW-1:0]    lane_below,
	output logic                                     out_valid,
	output logic [fsh_pkg::NUM_LANES-1:0]            on_bits,
	output logic                                     frame_end,
	output logic                                     wr_en,
	output logic [AW-1:0]                            wr_addr,
	output logic [fsh_pkg::NUM_LANES*SW-1:0]         wr_data,
	output logic                                     pend_set,
	output logic [AW-1:0]                            pend_addr,
	output logic [fsh_pkg::NUM_LANES*SW-1:0]         pend_data
);

	logic                            out_valid_q;
	logic [fsh_pkg::NUM_LANES-1:0]   on_q;
	logic                            frame_end_q;
	logic                            keep;

	// Nothing is saved for a row that does not follow. A pixel past the
	// first column settles the entry to its lower left; the last pixel of a
	// row also settles its own column, which is held in the one-entry store
	// until it can be written, unless the row is a single pixel wide.
	always_comb begin
		keep      = fire && !pos.last_row;
		wr_en     = keep && (!pos.first_col || pos.last_col);
		wr_addr   = pos.first_col ? col : col - AW'(1);
		wr_data   = pos.first_col ? lane_below : lane_left;
		pend_set  = keep && pos.last_col && !pos.first_col;
		pend_addr = col;
		pend_data = lane_below;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			on_q        <= lane_on;
			frame_end_q <= pos.last_col && pos.last_row;
		end
	end

	assign out_valid = out_valid_q;
	assign on_bits   = on_q;
	assign frame_end = frame_end_q;

endmodule

[hw/rtl/floyd_steinberg_halftone_unit.sv]
`timescale 1ns / 1ps
// Path: a pixel word accepted by the unit passes through stage 1 and the output register.
// Throughput: one pixel word per clock while the output is not stalled. The error carried to
//   the right-hand neighbour is formed and registered inside each lane; that loop sets the rate.
// Reset (arst_n low, asynchronous): pipeline, position counters and lane carries clear and
//   the registers take their defaults; the line buffer is not cleared, as row 0 discards what it reads.
// ----------------------------------------------------------------------------
// floyd_steinberg_halftone_unit: RGB error-diffusion halftoning
// Turns a raster-order RGB pixel stream into one on/off bit per channel,
// spreading each channel's quantisation error to its unvisited neighbours.
// ----------------------------------------------------------------------------
module floyd_steinberg_halftone_unit #(
	parameter int MAX_WIDTH     = fsh_pkg::MAX_WIDTH_DEF,
	parameter int FRACTION_BITS = fsh_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fsh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fsh_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Pixel input channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fsh_pkg::CHAN_W-1:0]        red_in,
	input  logic [fsh_pkg::CHAN_W-1:0]        green_in,
	input  logic [fsh_pkg::CHAN_W-1:0]        blue_in,
	// Halftone output channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              red_on,
	output logic                              green_on,
	output logic                              blue_on,
	output logic                              frame_end
);

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int CW  = AW + 1;
	localparam int WCW = (CW > fsh_pkg::WIDTH_W) ? CW : fsh_pkg::WIDTH_W;
	localparam int YW  = fsh_pkg::HEIGHT_W + 1;
	localparam int SW  = FRACTION_BITS + fsh_pkg::STORE_INT_W;
	localparam int NL  = fsh_pkg::NUM_LANES;
	localparam int DW  = NL * SW;
	localparam logic [WCW-1:0] MAXW_C = WCW'(MAX_WIDTH);

	// ------------------------------------------------------------------
	// Configuration registers. Writes are taken on every cycle; the user
	// must make them only while no pixel is in flight, as the datapath reads
	// them directly. The block itself does not enforce this.
	// ------------------------------------------------------------------
	logic [fsh_pkg::THR_W-1:0]    thr_q;
	logic [fsh_pkg::WIDTH_W-1:0]  width_q;
	logic [fsh_pkg::HEIGHT_W-1:0] height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= fsh_pkg::THR_RESET;
			width_q  <= fsh_pkg::WIDTH_RESET;
			height_q <= fsh_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fsh_pkg::REG_THRESHOLD: begin
					thr_q <= cfg_data[fsh_pkg::THR_W-1:0];
				end
				fsh_pkg::REG_WIDTH: begin
					width_q <= cfg_data[fsh_pkg::WIDTH_W-1:0];
				end
				fsh_pkg::REG_HEIGHT: begin
					height_q <= cfg_data[fsh_pkg::HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake. Stage 1 holds one pixel together with its line buffer
	// word; it moves to the output register whenever that register is
	// empty or being emptied, and a new pixel may enter in the same cycle.
	// ------------------------------------------------------------------
	logic valid_s1;
	logic fire;
	logic in_acc;

	always_comb begin
		fire     = valid_s1 && (!out_valid || !out_stall);
		in_stall = valid_s1 && !fire;
		in_acc   = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Frame position. A zero width or height acts as one, and a width above
	// the line buffer depth acts as the depth. A pixel whose column reaches
	// the width closes its row, and likewise for rows and the frame.
	// ------------------------------------------------------------------
	logic [AW-1:0]                col_q;
	logic [fsh_pkg::HEIGHT_W-1:0] row_q;
	logic [CW-1:0]                w_eff;
	logic [fsh_pkg::HEIGHT_W-1:0] h_eff;
	logic [CW-1:0]                x_inc;
	logic [YW-1:0]                y_inc;
	fsh_pkg::pos_t                pos_now;

	always_comb begin
		if (width_q == '0) begin
			w_eff = CW'(1);
		end else if (WCW'(width_q) > MAXW_C) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_q);
		end
		h_eff = (height_q == '0) ? fsh_pkg::HEIGHT_W'(1) : height_q;

		x_inc = CW'(col_q) + CW'(1);
		y_inc = YW'(row_q) + YW'(1);

		pos_now.first_col = (col_q == '0);
		pos_now.first_row = (row_q == '0);
		pos_now.last_col  = (x_inc >= w_eff);
		pos_now.last_row  = (y_inc >= YW'(h_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (pos_now.last_col) begin
				col_q <= '0;
				row_q <= pos_now.last_row ? '0 : y_inc[fsh_pkg::HEIGHT_W-1:0];
			end else begin
				col_q <= x_inc[AW-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 payload. The line buffer is read at the pixel's column as the
	// pixel enters, so its word lines up with the pixel in this stage.
	// ------------------------------------------------------------------
	logic [NL-1:0][fsh_pkg::CHAN_W-1:0] pix_s1;
	fsh_pkg::pos_t                      pos_s1;
	logic [AW-1:0]                      col_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= {blue_in, green_in, red_in};
			pos_s1 <= pos_now;
			col_s1 <= col_q;
		end
	end

	// ------------------------------------------------------------------
	// Line buffer: one word per column holding all three channels' error
	// sums for the row below.
	// ------------------------------------------------------------------
	logic [DW-1:0] row_word;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] wr_data;
	logic          pend_set;
	logic [AW-1:0] pend_addr;
	logic [DW-1:0] pend_data;

	fsh_linebuf #(
		.DEPTH (MAX_WIDTH),
		.DW    (DW)
	) u_linebuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_acc),
		.rd_addr   (col_q),
		.rd_data   (row_word),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.pend_set  (pend_set),
		.pend_addr (pend_addr),
		.pend_data (pend_data)
	);

	// ------------------------------------------------------------------
	// Channel lanes: red, green and blue run side by side, each with its
	// own carries, on the same position flags.
	// ------------------------------------------------------------------
	logic [NL-1:0]         lane_on;
	logic [NL-1:0][SW-1:0] lane_left;
	logic [NL-1:0][SW-1:0] lane_below;

	for (genvar i = 0; i < NL; i++) begin : g_lane
		fsh_lane #(
			.FRACTION_BITS (FRACTION_BITS)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.fire      (fire),
			.pos       (pos_s1),
			.thr       (thr_q),
			.pix       (pix_s1[i]),
			.row_err   (row_word[i*SW +: SW]),
			.on        (lane_on[i]),
			.left_val  (lane_left[i]),
			.below_val (lane_below[i])
		);
	end

	// ------------------------------------------------------------------
	// Merge: output word register and line buffer write requests.
	// ------------------------------------------------------------------
	logic [NL-1:0] on_bits;

	fsh_merge #(
		.AW (AW),
		.SW (SW)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.out_stall  (out_stall),
		.pos        (pos_s1),
		.col        (col_s1),
		.lane_on    (lane_on),
		.lane_left  (lane_left),
		.lane_below (lane_below),
		.out_valid  (out_valid),
		.on_bits    (on_bits),
		.frame_end  (frame_end),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.pend_set   (pend_set),
		.pend_addr  (pend_addr),
		.pend_data  (pend_data)
	);

	assign red_on   = on_bits[0];
	assign green_on = on_bits[1];
	assign blue_on  = on_bits[2];

endmodule

[hw/rtl/fsh_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsh_checker: port-level checks for the halftone unit
// Tracks words in flight from the two handshakes and checks the output
// channel and the unit's buffering against them.
// ----------------------------------------------------------------------------
module fsh_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic red_on,
	input logic green_on,
	input logic blue_on,
	input logic frame_end
);

	logic [2:0] in_flight_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= '0;
		end else if (in_acc && !out_acc) begin
			in_flight_q <= in_flight_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			in_flight_q <= in_flight_q - 3'd1;
		end
	end

	// A word on offer stays on offer while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word withdrawn while stalled");

	// Its fields do not move while stalled.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(red_on) && $stable(green_on) &&
			$stable(blue_on) && $stable(frame_end))
		else $error("output word changed while stalled");

	// An empty unit neither stalls its input nor offers a word.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q == 3'd0 |-> !in_stall && !out_valid)
		else $error("empty unit stalls input or shows a word");

	// At most two words are held: one in stage 1 and one at the output.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= 3'd2)
		else $error("words in flight exceed the pipeline depth");

endmodule

bind floyd_steinberg_halftone_unit fsh_checker u_fsh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.red_on    (red_on),
	.green_on  (green_on),
	.blue_on   (blue_on),
	.frame_end (frame_end)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the error-diffusion halftone unit
// Streams RGB pixel words through the unit under several frame sizes and
// thresholds, predicts every on/off word with an independent fixed-point copy
// of the diffusion arithmetic and compares each output word as it leaves.
// ----------------------------------------------------------------------------
module tb_top;

	// Fixed-point scale and limits of the predictor, at the unit's default build.
	localparam int     FRAC         = fsh_pkg::FRACTION_BITS_DEF;
	localparam int     LINE_DEPTH   = fsh_pkg::MAX_WIDTH_DEF;
	localparam longint SAT_FX       = longint'(fsh_pkg::SAT_INT) << FRAC;
	localparam longint FULL_FX      = longint'(fsh_pkg::FULL_LEVEL) << FRAC;
	// The fourth register index decodes to nothing; writing it must change nothing.
	localparam logic [fsh_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	// Watchdog limit, far beyond the slowest legal run.
	localparam int     RUN_LIMIT_NS = 2_000_000;

	typedef struct packed {
		logic red;
		logic green;
		logic blue;
		logic frame_last;
	} dots_t;

	// Mirrors the unit's arithmetic and position counters. Every accepted pixel
	// word is turned into the expected output word and queued; output words are
	// compared in order against that queue.
	class halftone_tracker;
		logic [fsh_pkg::THR_W-1:0]    threshold;
		logic [fsh_pkg::WIDTH_W-1:0]  width_reg;
		logic [fsh_pkg::HEIGHT_W-1:0] height_reg;
		longint line_err [LINE_DEPTH][3];
		longint carry_right [3];
		longint below_sum [3];
		longint diag_err [3];
		int     col;
		int     row;
		dots_t  dots_due [$];
		int     pixels;
		int     checked;
		int     frames;
		int     faults;
		int     reg_writes;

		function new();
			threshold  = fsh_pkg::THR_RESET;
			width_reg  = fsh_pkg::WIDTH_RESET;
			height_reg = fsh_pkg::HEIGHT_RESET;
			for (int i = 0; i < LINE_DEPTH; i++) begin
				for (int c = 0; c < 3; c++) begin
					line_err[i][c] = 0;
				end
			end
			for (int c = 0; c < 3; c++) begin
				carry_right[c] = 0;
				below_sum[c]   = 0;
				diag_err[c]    = 0;
			end
			col        = 0;
			row        = 0;
			pixels     = 0;
			checked    = 0;
			frames     = 0;
			faults     = 0;
			reg_writes = 0;
		endfunction

		function int eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > LINE_DEPTH) return LINE_DEPTH;
			return width_reg;
		endfunction

		function int eff_height();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		// Pixels still to come before the current frame closes.
		function int left_in_frame();
			int in_row;
			int rows_after;
			in_row     = (col + 1 >= eff_width()) ? 1 : eff_width() - col;
			rows_after = (row + 1 >= eff_height()) ? 0 : eff_height() - row - 1;
			return in_row + rows_after * eff_width();
		endfunction

		function void set_register(logic [fsh_pkg::CFG_IDX_W-1:0] idx,
				logic [fsh_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				fsh_pkg::REG_THRESHOLD: begin
					threshold = data[fsh_pkg::THR_W-1:0];
				end
				fsh_pkg::REG_WIDTH: begin
					width_reg = data[fsh_pkg::WIDTH_W-1:0];
				end
				fsh_pkg::REG_HEIGHT: begin
					height_reg = data[fsh_pkg::HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
			reg_writes++;
		endfunction

		function longint clamp(longint v);
			if (v > SAT_FX) return SAT_FX;
			if (v < -SAT_FX) return -SAT_FX;
			return v;
		endfunction

		// Weighted share in sixteenths, rounded towards minus infinity.
		function longint share(longint e, logic [fsh_pkg::WEIGHT_W-1:0] w);
			longint p;
			p = e * longint'(w);
			return clamp(p >>> fsh_pkg::WEIGHT_SHIFT);
		endfunction

		function void absorb_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			logic [7:0] level [3];
			logic       on [3];
			logic       last_col;
			logic       last_row;
			longint     v;
			longint     e;
			longint     thr_fx;
			dots_t      want;
			level[0] = r;
			level[1] = g;
			level[2] = b;
			last_col = (col + 1 >= eff_width());
			last_row = (row + 1 >= eff_height());
			thr_fx   = longint'(threshold) << FRAC;
			if (col == 0) begin
				for (int c = 0; c < 3; c++) begin
					carry_right[c] = 0;
					below_sum[c]   = 0;
					diag_err[c]    = 0;
				end
			end
			for (int c = 0; c < 3; c++) begin
				v = (longint'(level[c]) << FRAC) + carry_right[c];
				// The line buffer only holds anything once the first row is done.
				if (row > 0) v += line_err[col][c];
				v     = clamp(v);
				on[c] = (v >= thr_fx);
				e     = v - (on[c] ? FULL_FX : 0);
				carry_right[c] = last_col ? 0 : share(e, fsh_pkg::W_RIGHT);
				if (!last_row) begin
					if (col > 0) begin
						line_err[col - 1][c] = clamp(below_sum[c] + share(e, fsh_pkg::W_DOWN_LEFT));
					end
					below_sum[c] = clamp(diag_err[c] + share(e, fsh_pkg::W_DOWN));
					diag_err[c]  = share(e, fsh_pkg::W_DOWN_RIGHT);
					if (last_col) line_err[col][c] = below_sum[c];
				end
			end
			want.red        = on[0];
			want.green      = on[1];
			want.blue       = on[2];
			want.frame_last = last_col && last_row;
			dots_due.push_back(want);
			pixels++;
			if (last_col) begin
				col = 0;
				row = last_row ? 0 : row + 1;
				if (last_row) frames++;
			end else begin
				col++;
			end
		endfunction

		function void compare_dots(logic r, logic g, logic b, logic fe);
			dots_t want;
			if (dots_due.size() == 0) begin
				$error("halftone word presented with no pixel outstanding");
				faults++;
				return;
			end
			want = dots_due.pop_front();
			checked++;
			if (r !== want.red) begin
				$error("red_on: expected %0d, actual %0d", want.red, r);
				faults++;
			end
			if (g !== want.green) begin
				$error("green_on: expected %0d, actual %0d", want.green, g);
				faults++;
			end
			if (b !== want.blue) begin
				$error("blue_on: expected %0d, actual %0d", want.blue, b);
				faults++;
			end
			if (fe !== want.frame_last) begin
				$error("frame_end: expected %0d, actual %0d", want.frame_last, fe);
				faults++;
			end
		endfunction
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [fsh_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [fsh_pkg::CFG_DATA_W-1:0]     cfg_data;
	logic                               in_valid;
	logic                               in_stall;
	logic [fsh_pkg::CHAN_W-1:0]         red_in;
	logic [fsh_pkg::CHAN_W-1:0]         green_in;
	logic [fsh_pkg::CHAN_W-1:0]         blue_in;
	logic                               out_valid;
	logic                               out_stall;
	logic                               red_on;
	logic                               green_on;
	logic                               blue_on;
	logic                               frame_end;

	halftone_tracker tracker;

	// Idling controls shared between the stimulus and the receiver process.
	int gap_max;        // longest gap between bursts of input words
	int burst_left;     // words left in the current input burst
	int stall_pct;      // chance, in percent, that a receiver run is a stall run
	int hold_request;   // a long receiver hold-off, in cycles, waiting to start

	floyd_steinberg_halftone_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_on    (red_on),
		.green_on  (green_on),
		.blue_on   (blue_on),
		.frame_end (frame_end)
	);

	// 2 ns clock: low for the first half, so the first rising edge falls at 1 ns.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// All three channels are observed in one process at the rising edge. Inputs
	// only ever move at the falling edge, so the values seen here are those the
	// unit itself sampled. Input words are noted before output words are checked,
	// so a word's expectation is always queued before its result can turn up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) tracker.set_register(cfg_index, cfg_data);
			if (in_valid && !in_stall) tracker.absorb_pixel(red_in, green_in, blue_in);
			if (out_valid && !out_stall) tracker.compare_dots(red_on, green_on, blue_on, frame_end);
		end
	end

	// Receiver: alternates stall and flow runs of random length, weighted by
	// stall_pct. A hold-off request overrides the pattern for that many cycles,
	// which lets the unit fill and push back on the sender.
	initial begin
		int run_left;
		int hold_left;
		run_left  = 0;
		hold_left = 0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (run_left != 0) begin
				run_left--;
			end else begin
				out_stall <= ($urandom_range(1, 100) <= stall_pct);
				run_left  = $urandom_range(0, 5);
			end
		end
	end

	// Overall watchdog.
	initial begin
		#(RUN_LIMIT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Bits above the register's width are don't-care; fill them at random.
	function automatic logic [fsh_pkg::CFG_DATA_W-1:0] with_junk(input int value,
			input int field_w);
		logic [fsh_pkg::CFG_DATA_W-1:0] data;
		data = fsh_pkg::CFG_DATA_W'($urandom);
		for (int i = 0; i < field_w; i++) data[i] = value[i];
		return data;
	endfunction

	// A channel level biased towards the two extremes.
	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic write_register(input logic [fsh_pkg::CFG_IDX_W-1:0] idx,
			input logic [fsh_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drops the input valid for a number of cycles; the payload wanders meanwhile.
	task automatic idle_input(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
			red_in   <= 8'($urandom);
			green_in <= 8'($urandom);
			blue_in  <= 8'($urandom);
		end
	endtask

	// Offers one pixel word and returns at the edge that takes it. Words go out
	// in bursts of random length separated by random gaps; valid stays high
	// across a burst and the payload holds still while the unit stalls.
	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) idle_input(gap);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		red_in   <= r;
		green_in <= g;
		blue_in  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Registers only change once every outstanding word has come back. Each
	// pixel yields exactly one word, so an empty queue means the unit is idle.
	task automatic wait_for_dots();
		while (tracker.dots_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Picks a fresh setting between random phases. Sizes may change mid-frame,
	// but never so that a later row reads a line buffer entry the unit has not
	// yet written: the width only grows at the very start of a frame, and a row
	// that has begun as the last one is not turned back into an ordinary row.
	task automatic retune();
		int  new_w;
		int  new_h;
		logic frame_start;
		frame_start = (tracker.col == 0) && (tracker.row == 0);
		if ($urandom_range(0, 7) == 0) begin
			write_register(fsh_pkg::REG_THRESHOLD,
				with_junk($urandom_range(257, 511), fsh_pkg::THR_W));
		end else begin
			write_register(fsh_pkg::REG_THRESHOLD,
				with_junk($urandom_range(0, 256), fsh_pkg::THR_W));
		end
		if (frame_start) begin
			case ($urandom_range(0, 9))
				0: new_w = 0;
				1: new_w = $urandom_range(13, 80);
				default: new_w = $urandom_range(1, 12);
			endcase
			new_h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
			write_register(fsh_pkg::REG_WIDTH, with_junk(new_w, fsh_pkg::WIDTH_W));
			write_register(fsh_pkg::REG_HEIGHT, fsh_pkg::CFG_DATA_W'(new_h));
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				new_w = $urandom_range(0, tracker.eff_width());
				write_register(fsh_pkg::REG_WIDTH, with_junk(new_w, fsh_pkg::WIDTH_W));
			end
			if ($urandom_range(0, 2) == 0) begin
				if (tracker.row + 1 >= tracker.eff_height() && tracker.col != 0) begin
					new_h = $urandom_range(0, tracker.row + 1);
				end else begin
					new_h = $urandom_range(0, 8);
				end
				write_register(fsh_pkg::REG_HEIGHT, fsh_pkg::CFG_DATA_W'(new_h));
			end
		end
	endtask

	initial begin
		int n;
		int phase_no;
		int random_sent;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = fsh_pkg::REG_THRESHOLD;
		cfg_data     = '0;
		in_valid     = 1'b0;
		red_in       = '0;
		green_in     = '0;
		blue_in      = '0;
		gap_max      = 2;
		burst_left   = 0;
		stall_pct    = 30;
		hold_request = 0;
		phase_no     = 0;
		random_sent  = 0;
		tracker      = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A 4 x 3 frame at the reset threshold: first row, row starts, last row
		// and every channel at its extremes and around the threshold.
		write_register(fsh_pkg::REG_THRESHOLD, with_junk(128, fsh_pkg::THR_W));
		write_register(fsh_pkg::REG_WIDTH, with_junk(4, fsh_pkg::WIDTH_W));
		write_register(fsh_pkg::REG_HEIGHT, 14'd3);
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd127, 8'd128, 8'd129);
		push_pixel(8'd128, 8'd127, 8'd255);
		push_pixel(8'd1, 8'd2, 8'd4);
		push_pixel(8'd8, 8'd16, 8'd32);
		push_pixel(8'd64, 8'd170, 8'd85);
		push_pixel(8'd254, 8'd253, 8'd251);
		push_pixel(8'd247, 8'd239, 8'd223);
		push_pixel(8'd191, 8'd127, 8'd0);
		push_pixel(8'd255, 8'd0, 8'd255);
		push_pixel(8'd0, 8'd255, 8'd0);
		idle_input(1);
		wait_for_dots();

		// Zero width and zero height both act as one: every pixel is a frame.
		// A zero threshold turns every channel on.
		write_register(fsh_pkg::REG_THRESHOLD, with_junk(0, fsh_pkg::THR_W));
		write_register(fsh_pkg::REG_WIDTH, with_junk(0, fsh_pkg::WIDTH_W));
		write_register(fsh_pkg::REG_HEIGHT, 14'd0);
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd255, 8'd255, 8'd255);
		idle_input(1);
		wait_for_dots();

		// The unused index must leave everything alone. With the top threshold a
		// full-scale pixel stays off until enough error has built up.
		write_register(REG_SPARE, fsh_pkg::CFG_DATA_W'($urandom));
		write_register(fsh_pkg::REG_THRESHOLD, with_junk(256, fsh_pkg::THR_W));
		write_register(fsh_pkg::REG_WIDTH, with_junk(2, fsh_pkg::WIDTH_W));
		write_register(fsh_pkg::REG_HEIGHT, 14'd2);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd255, 8'd200, 8'd255);
		push_pixel(8'd255, 8'd255, 8'd200);
		push_pixel(8'd200, 8'd255, 8'd255);
		idle_input(1);
		wait_for_dots();

		// A frame 8192 rows tall, one pixel wide, then the height is cut to three
		// part way down: the next pixel is past the new limit and ends the frame.
		write_register(fsh_pkg::REG_THRESHOLD, with_junk(128, fsh_pkg::THR_W));
		write_register(fsh_pkg::REG_WIDTH, with_junk(1, fsh_pkg::WIDTH_W));
		write_register(fsh_pkg::REG_HEIGHT, 14'd8192);
		repeat (5) push_pixel(pick_level(), pick_level(), pick_level());
		idle_input(1);
		wait_for_dots();
		write_register(fsh_pkg::REG_HEIGHT, 14'd3);
		push_pixel(pick_level(), pick_level(), pick_level());
		idle_input(1);
		wait_for_dots();

		// A frame of two rows whose width is above the line buffer's size and is
		// clamped to it, so the first row writes the whole buffer. The width is
		// then cut at the start of the second row, which reads the front back.
		write_register(fsh_pkg::REG_WIDTH, with_junk(2047, fsh_pkg::WIDTH_W));
		write_register(fsh_pkg::REG_HEIGHT, 14'd2);
		gap_max   = 1;
		stall_pct = 20;
		repeat (LINE_DEPTH) push_pixel(pick_level(), pick_level(), pick_level());
		idle_input(1);
		wait_for_dots();
		write_register(fsh_pkg::REG_WIDTH, with_junk(64, fsh_pkg::WIDTH_W));
		repeat (64) push_pixel(pick_level(), pick_level(), pick_level());
		idle_input(1);

		// Random phases, mostly whole frames with random content, some cut short
		// so that the next setting lands mid-frame. The first phase holds the
		// receiver off for a long stretch while words keep coming.
		while (random_sent < 100) begin
			wait_for_dots();
			retune();
			if ($urandom_range(0, 4) < 3) begin
				n = tracker.left_in_frame() +
					$urandom_range(0, 2) * tracker.eff_width() * tracker.eff_height();
			end else begin
				n = $urandom_range(1, 40);
			end
			if (n > 40) n = 40;
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 80;
			endcase
			if (phase_no == 0) begin
				gap_max      = 0;
				hold_request = $urandom_range(30, 60);
				if (n < 64) n = 64;
			end
			repeat (n) push_pixel(pick_level(), pick_level(), pick_level());
			idle_input(1);
			random_sent += n;
			phase_no++;
		end

		while (tracker.dots_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		$display("Run covered %0d pixel words over %0d completed frames and %0d register writes,",
			tracker.pixels, tracker.frames, tracker.reg_writes);
		$display("with %0d halftone words checked across %0d random phases.",
			tracker.checked, phase_no);
		if (tracker.faults == 0 && tracker.dots_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
